>>> rtl/core/tqvg_pkg.sv
package tqvg_pkg;

  // Default map limits (tiles)
  localparam int unsigned MaxMapWidthDef  = 1024;
  localparam int unsigned MaxMapHeightDef = 1024;

  // Field widths
  localparam int unsigned TileNumW  = 16;  // magnitude bits of a non-empty tile number
  localparam int unsigned MapWidthW = 11;
  localparam int unsigned SizeW     = 8;   // tile_width, tile_height, atlas_tiles_per_row
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned PosW      = 18;
  localparam int unsigned TexXW     = 16;
  localparam int unsigned TexYW     = 24;
  localparam int unsigned SlotW     = 20;  // vertex_index without the corner bits
  localparam int unsigned CornerW   = 2;
  localparam int unsigned VertexW   = SlotW + CornerW;

  // Stream packing
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 104;

  // Reset values of the registers
  localparam logic [MapWidthW-1:0] MapWidthRst   = 11'd16;
  localparam logic [SizeW-1:0]     TileWidthRst  = 8'd32;
  localparam logic [SizeW-1:0]     TileHeightRst = 8'd32;
  localparam logic [SizeW-1:0]     AtlasPerRowRst = 8'd8;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MAP_WIDTH     = 2'd0,
    REG_TILE_WIDTH    = 2'd1,
    REG_TILE_HEIGHT   = 2'd2,
    REG_ATLAS_PER_ROW = 2'd3
  } cfg_reg_e;

  typedef enum logic [CornerW-1:0] {
    CORNER_TL = 2'd0,
    CORNER_TR = 2'd1,
    CORNER_BR = 2'd2,
    CORNER_BL = 2'd3
  } corner_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_MUL,
    ST_EMIT
  } seq_state_e;

  // Control of a bit-serial unit: load operands, then shift one bit per step
  typedef struct packed {
    logic load;
    logic step;
  } ser_ctl_t;

endpackage

>>> rtl/core/tqvg_div.sv
// Restoring divider, one quotient bit per step, MSB first
module tqvg_div import tqvg_pkg::*; (
  input  logic                clk_i,
  input  ser_ctl_t            ctl_i,
  input  logic [TileNumW-1:0] dividend_i,
  input  logic [SizeW-1:0]    divisor_i,
  output logic [TileNumW-1:0] quot_o,
  output logic [SizeW-1:0]    rem_o
);

  logic [TileNumW-1:0] quot_q, quot_d;
  logic [SizeW-1:0]    rem_q, rem_d;
  logic [SizeW-1:0]    div_q, div_d;
  logic [SizeW:0]      shifted;
  logic [SizeW:0]      diff;
  logic                fits;

  // Trial subtraction of the divisor from the shifted partial remainder
  always_comb begin
    shifted = {rem_q, quot_q[TileNumW-1]};
    diff    = shifted - {1'b0, div_q};
    fits    = (shifted >= {1'b0, div_q});
    quot_d  = quot_q;
    rem_d   = rem_q;
    div_d   = div_q;
    if (ctl_i.load) begin
      quot_d = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (ctl_i.step) begin
      quot_d = {quot_q[TileNumW-2:0], fits};
      rem_d  = fits ? diff[SizeW-1:0] : shifted[SizeW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    div_q  <= div_d;
  end

  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

>>> rtl/core/tqvg_mul.sv
// Shift-add multiplier, one multiplier bit per step, MSB first.
// Product is kept modulo 2^AW; a_i must hold steady while stepping.
module tqvg_mul import tqvg_pkg::*; #(
  parameter int unsigned AW = 18,
  parameter int unsigned BW = 8
) (
  input  logic          clk_i,
  input  ser_ctl_t      ctl_i,
  input  logic [AW-1:0] a_i,
  input  logic [BW-1:0] b_i,
  output logic [AW-1:0] p_o
);

  logic [AW-1:0] acc_q, acc_d;
  logic [BW-1:0] b_q, b_d;

  always_comb begin
    acc_d = acc_q;
    b_d   = b_q;
    if (ctl_i.load) begin
      acc_d = '0;
      b_d   = b_i;
    end else if (ctl_i.step) begin
      acc_d = {acc_q[AW-2:0], 1'b0} + (b_q[BW-1] ? a_i : '0);
      b_d   = b_q << 1;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    b_q   <= b_d;
  end

  assign p_o = acc_q;

endmodule

>>> rtl/core/tile_quad_vertex_generator_top.sv
// Tile quad vertex generator. Tile numbers arrive in map row-major order on the
// slave stream (tuser high restarts column and row at zero before that tile).
// A tile with the sign bit set is empty: it is taken while idle, moves the map
// position on and gives no item. Any other tile gives four items, top-left,
// top-right, bottom-right, bottom-left, with tlast on the fourth. A non-empty
// tile closes the input until its last corner is handed out: it is accepted,
// the bit-serial restoring divider splits the tile number into atlas column and
// row while the map slot product runs alongside, the shift-add multipliers
// scale by tile size, and the corners are handed out while the output takes
// them. The user must write registers through cfg_* only while no tile is in
// flight; the block itself does not enforce it.
module tile_quad_vertex_generator_top import tqvg_pkg::*; #(
  parameter int unsigned MAX_MAP_WIDTH  = MaxMapWidthDef,
  parameter int unsigned MAX_MAP_HEIGHT = MaxMapHeightDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration write port
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [MapWidthW-1:0] cfg_wdata_i,
  // Tile stream in
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [InDataW-1:0]   s_axis_tdata,  // [16:0] tile_number, zero pad
  input  logic                 s_axis_tuser,  // [0] first_of_map
  // Corner stream out
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OutDataW-1:0]  m_axis_tdata,  // [21:0] vertex_index, [23:22] corner,
                                              // [41:24] pos_x, [59:42] pos_y,
                                              // [75:60] tex_x, [99:76] tex_y, zero pad
  output logic                 m_axis_tlast   // last
);

  localparam int unsigned ColW  = (MAX_MAP_WIDTH > 1) ? $clog2(MAX_MAP_WIDTH) : 1;
  localparam int unsigned RowW  = (MAX_MAP_HEIGHT > 1) ? $clog2(MAX_MAP_HEIGHT) : 1;
  localparam int unsigned EwW   = $clog2(MAX_MAP_WIDTH + 1);
  localparam int unsigned PhLen = (EwW > TileNumW) ? EwW : TileNumW;
  localparam int unsigned CntW  = $clog2(PhLen);

  // Configuration registers
  logic [MapWidthW-1:0] map_width_q;
  logic [SizeW-1:0]     tile_width_q, tile_height_q, atlas_per_row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_width_q     <= MapWidthRst;
      tile_width_q    <= TileWidthRst;
      tile_height_q   <= TileHeightRst;
      atlas_per_row_q <= AtlasPerRowRst;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_MAP_WIDTH:     map_width_q     <= cfg_wdata_i;
        REG_TILE_WIDTH:    tile_width_q    <= cfg_wdata_i[SizeW-1:0];
        REG_TILE_HEIGHT:   tile_height_q   <= cfg_wdata_i[SizeW-1:0];
        REG_ATLAS_PER_ROW: atlas_per_row_q <= cfg_wdata_i[SizeW-1:0];
        default: ;
      endcase
    end
  end

  // Effective map width clamped to 1 .. MAX_MAP_WIDTH, atlas width of 0 acts as 1
  logic [EwW-1:0]   eff_width;
  logic [SizeW-1:0] per_row;

  always_comb begin
    if (map_width_q == '0) begin
      eff_width = EwW'(1);
    end else if (32'(map_width_q) > 32'(MAX_MAP_WIDTH)) begin
      eff_width = EwW'(MAX_MAP_WIDTH);
    end else begin
      eff_width = EwW'(map_width_q);
    end
    per_row = (atlas_per_row_q == '0) ? SizeW'(1) : atlas_per_row_q;
  end

  // Sequencer
  seq_state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  corner_e corner_q, corner_d, corner_nxt;
  logic out_valid_q, out_valid_d;
  logic in_fire, in_empty, in_first, emit_fire, emit_done;
  ser_ctl_t div_ctl, slot_ctl, scale_ctl;

  assign in_empty  = s_axis_tdata[TileNumW];
  assign in_first  = s_axis_tuser;
  assign in_fire   = s_axis_tvalid && s_axis_tready;
  assign emit_fire = (state_q == ST_EMIT) && (!out_valid_q || m_axis_tready);
  assign emit_done = emit_fire && (corner_q == CORNER_BL);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_fire && !in_empty) state_d = ST_CALC;
      ST_CALC: if (cnt_q == CntW'(PhLen - 1)) state_d = ST_MUL;
      ST_MUL:  if (cnt_q == CntW'(SizeW - 1)) state_d = ST_EMIT;
      ST_EMIT: if (emit_done) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready  = 1'b0;
    div_ctl        = '0;
    slot_ctl       = '0;
    scale_ctl      = '0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready  = 1'b1;
        div_ctl.load   = in_fire;
        slot_ctl.load  = in_fire;
        scale_ctl.load = in_fire;
      end
      ST_CALC: begin
        div_ctl.step  = (32'(cnt_q) < 32'(TileNumW));
        slot_ctl.step = (32'(cnt_q) < 32'(EwW));
      end
      ST_MUL:  scale_ctl.step = 1'b1;
      ST_EMIT: ;
      default: ;
    endcase
  end

  // Step counter and corner counter
  always_comb begin
    cnt_d = cnt_q;
    if (state_d != state_q) begin
      cnt_d = '0;
    end else if (state_q == ST_CALC || state_q == ST_MUL) begin
      cnt_d = cnt_q + CntW'(1);
    end
    case (corner_q)
      CORNER_TL: corner_nxt = CORNER_TR;
      CORNER_TR: corner_nxt = CORNER_BR;
      CORNER_BR: corner_nxt = CORNER_BL;
      CORNER_BL: corner_nxt = CORNER_TL;
      default:   corner_nxt = CORNER_TL;
    endcase
    corner_d = emit_fire ? corner_nxt : corner_q;
    out_valid_d = emit_fire ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      corner_q    <= CORNER_TL;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      corner_q    <= corner_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Map position: column and row of the tile in flight, advanced after it
  logic [ColW-1:0] col_q, col_d, col_src;
  logic [RowW-1:0] row_q, row_d, row_src;
  logic [ColW:0]   col_inc;
  logic [RowW:0]   row_inc;
  logic            col_wrap, row_room;

  always_comb begin
    col_src = (in_fire && in_first) ? '0 : col_q;
    row_src = (in_fire && in_first) ? '0 : row_q;
    col_inc  = {1'b0, col_src} + (ColW + 1)'(1);
    row_inc  = {1'b0, row_src} + (RowW + 1)'(1);
    col_wrap = (32'(col_inc) >= 32'(eff_width));
    row_room = (32'(row_inc) < 32'(MAX_MAP_HEIGHT));
    col_d = col_q;
    row_d = row_q;
    if ((in_fire && in_empty) || emit_done) begin
      col_d = col_wrap ? '0 : col_inc[ColW-1:0];
      row_d = (col_wrap && row_room) ? row_inc[RowW-1:0] : row_src;
    end else if (in_fire) begin
      col_d = col_src;
      row_d = row_src;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Atlas column and row
  logic [TileNumW-1:0] atlas_row;
  logic [SizeW-1:0]    atlas_col;

  tqvg_div u_div (
    .clk_i      (clk_i),
    .ctl_i      (div_ctl),
    .dividend_i (s_axis_tdata[TileNumW-1:0]),
    .divisor_i  (per_row),
    .quot_o     (atlas_row),
    .rem_o      (atlas_col)
  );

  // Serial products
  logic [SlotW-1:0] slot_base;
  logic [PosW-1:0]  px_base, py_base;
  logic [TexXW-1:0] tx_base;
  logic [TexYW-1:0] ty_base;

  tqvg_mul #(.AW(SlotW), .BW(EwW)) u_mul_slot (
    .clk_i (clk_i),
    .ctl_i (slot_ctl),
    .a_i   (SlotW'(row_q)),
    .b_i   (eff_width),
    .p_o   (slot_base)
  );

  tqvg_mul #(.AW(PosW), .BW(SizeW)) u_mul_px (
    .clk_i (clk_i),
    .ctl_i (scale_ctl),
    .a_i   (PosW'(col_q)),
    .b_i   (tile_width_q),
    .p_o   (px_base)
  );

  tqvg_mul #(.AW(PosW), .BW(SizeW)) u_mul_py (
    .clk_i (clk_i),
    .ctl_i (scale_ctl),
    .a_i   (PosW'(row_q)),
    .b_i   (tile_height_q),
    .p_o   (py_base)
  );

  tqvg_mul #(.AW(TexXW), .BW(SizeW)) u_mul_tx (
    .clk_i (clk_i),
    .ctl_i (scale_ctl),
    .a_i   (TexXW'(atlas_col)),
    .b_i   (tile_width_q),
    .p_o   (tx_base)
  );

  tqvg_mul #(.AW(TexYW), .BW(SizeW)) u_mul_ty (
    .clk_i (clk_i),
    .ctl_i (scale_ctl),
    .a_i   (TexYW'(atlas_row)),
    .b_i   (tile_height_q),
    .p_o   (ty_base)
  );

  // Corner offsets and output register
  logic             dx, dy;
  logic [SlotW-1:0] slot;
  logic [SlotW-1:0] slot_q;
  corner_e          ocorner_q;
  logic [PosW-1:0]  pos_x_q, pos_y_q;
  logic [TexXW-1:0] tex_x_q;
  logic [TexYW-1:0] tex_y_q;
  logic             last_q;

  assign dx   = (corner_q == CORNER_TR) || (corner_q == CORNER_BR);
  assign dy   = (corner_q == CORNER_BR) || (corner_q == CORNER_BL);
  assign slot = slot_base + SlotW'(col_q);

  always_ff @(posedge clk_i) begin
    if (emit_fire) begin
      slot_q    <= slot;
      ocorner_q <= corner_q;
      pos_x_q   <= px_base + (dx ? PosW'(tile_width_q) : '0);
      pos_y_q   <= py_base + (dy ? PosW'(tile_height_q) : '0);
      tex_x_q   <= tx_base + (dx ? TexXW'(tile_width_q) : '0);
      tex_y_q   <= ty_base + (dy ? TexYW'(tile_height_q) : '0);
      last_q    <= (corner_q == CORNER_BL);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = last_q;
  assign m_axis_tdata  = {(OutDataW - VertexW - CornerW - 2 * PosW - TexXW - TexYW)'(0),
                          tex_y_q, tex_x_q, pos_y_q, pos_x_q, ocorner_q, slot_q, ocorner_q};

endmodule

>>> rtl/core/tqvg_checker.sv
// Port-level checks on the vertex generator
module tqvg_checker import tqvg_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic [InDataW-1:0]  s_axis_tdata,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic                m_axis_tlast
);

  // A stalled output item stays valid
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output item dropped while stalled");

  // tlast marks exactly the bottom-left corner
  a_last_corner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[23:22] == CORNER_BL)))
    else $error("tlast does not match the fourth corner");

  // Vertex index low bits carry the corner
  a_slot_corner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[1:0] == m_axis_tdata[23:22]))
    else $error("vertex_index and corner disagree");

  // A non-empty tile keeps the input closed on the next cycle
  a_busy_after_tile: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !s_axis_tdata[TileNumW] |=> !s_axis_tready)
    else $error("input taken while a tile is in flight");

endmodule

bind tile_quad_vertex_generator_top tqvg_checker u_tqvg_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
